/* rtl/core/light_pulse_morse_decoder_unit_macros.svh */
// assertion macros for the light pulse morse decoder
// no dependencies; the assertions compile away when SYNTH is defined
`ifndef LIGHT_PULSE_MORSE_DECODER_UNIT_MACROS_SVH
`define LIGHT_PULSE_MORSE_DECODER_UNIT_MACROS_SVH
`ifndef SYNTH
// property must hold at every edge outside reset
`define LPMD_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// condition must never be seen outside reset
`define LPMD_ASSERT_NEVER(lbl, clk, rst, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define LPMD_ASSERT(lbl, clk, rst, prop, msg)
`define LPMD_ASSERT_NEVER(lbl, clk, rst, cond, msg)
`endif
`endif

/* rtl/core/lpmd_pkg.sv */
// shared constants and types for the light pulse morse decoder
// no dependencies
`default_nettype none
package lpmd_pkg;

  localparam int BUFFER_SLOTS = 16;
  localparam int SLOT_W       = $clog2(BUFFER_SLOTS);

  localparam int LEVEL_W    = 12;
  localparam int TIME_W     = 32;
  localparam int LIMIT_W    = 16;
  localparam int CODE_W     = 8;
  localparam int EVENT_W    = 2;
  localparam int SLOT_IDX_W = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TRIGGER_LEVEL = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SHORT_LIMIT   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_LIMIT    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RIGHT_CODE    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LEFT_CODE     = 3'd4;

  // register reset values
  localparam logic [LEVEL_W-1:0] TRIGGER_LEVEL_RST = 12'd2048;
  localparam logic [LIMIT_W-1:0] SHORT_LIMIT_RST   = 16'd300;
  localparam logic [LIMIT_W-1:0] LONG_LIMIT_RST    = 16'd900;
  localparam logic [CODE_W-1:0]  RIGHT_CODE_RST    = 8'd106;
  localparam logic [CODE_W-1:0]  LEFT_CODE_RST     = 8'd149;

  // letter events
  localparam logic [EVENT_W-1:0] EV_NONE    = 2'd0;
  localparam logic [EVENT_W-1:0] EV_RIGHT   = 2'd1;
  localparam logic [EVENT_W-1:0] EV_LEFT    = 2'd2;
  localparam logic [EVENT_W-1:0] EV_UNKNOWN = 2'd3;

  // element symbols
  localparam logic [1:0] ELEM_DOT  = 2'b01;
  localparam logic [1:0] ELEM_DASH = 2'b10;

  typedef struct packed {
    logic [LEVEL_W-1:0] trigger_level;
    logic [LIMIT_W-1:0] short_limit_ms;
    logic [LIMIT_W-1:0] long_limit_ms;
    logic [CODE_W-1:0]  right_letter_code;
    logic [CODE_W-1:0]  left_letter_code;
  } lpmd_cfg_t;

  typedef struct packed {
    logic [EVENT_W-1:0]    letter_event;
    logic [SLOT_IDX_W-1:0] slot_index;
    logic                  finished;
    logic                  line_on;
  } lpmd_result_t;

endpackage
`default_nettype wire

/* rtl/core/lpmd_in_if.sv */
// sample channel: valid/ready handshake with left, right level and timestamp
// depends on lpmd_pkg
`default_nettype none
interface lpmd_in_if
  import lpmd_pkg::*;
;
  logic               valid;
  logic               ready;
  logic [LEVEL_W-1:0] left_level;
  logic [LEVEL_W-1:0] right_level;
  logic [TIME_W-1:0]  time_ms;

  modport source (output valid, output left_level, output right_level, output time_ms,
                  input ready);
  modport sink (input valid, input left_level, input right_level, input time_ms,
                output ready);
endinterface
`default_nettype wire

/* rtl/core/lpmd_out_if.sv */
// result channel: valid/ready handshake with letter event, slot and status
// depends on lpmd_pkg
`default_nettype none
interface lpmd_out_if
  import lpmd_pkg::*;
;
  logic                  valid;
  logic                  ready;
  logic [EVENT_W-1:0]    letter_event;
  logic [SLOT_IDX_W-1:0] slot_index;
  logic                  finished;
  logic                  line_on;

  modport source (output valid, output letter_event, output slot_index, output finished,
                  output line_on, input ready);
  modport sink (input valid, input letter_event, input slot_index, input finished,
                input line_on, output ready);
endinterface
`default_nettype wire

/* rtl/core/light_pulse_morse_decoder_unit.sv */
// top level of the light pulse morse decoder: input register, step logic, result register
// depends on lpmd_pkg, lpmd_in_if, lpmd_out_if, lpmd_cfg_regs, lpmd_line_detect,
// lpmd_step_core and the assertion macro header
`default_nettype none
`include "light_pulse_morse_decoder_unit_macros.svh"

// Decodes morse-style light pulses. Each sample beat carries a left and right light
// level and a millisecond timestamp; the line is on when the mean of the two levels
// is above trigger_level and each is above half of it. High pulses become dots or
// dashes, short gaps separate elements, medium gaps end a letter which is matched
// against right_letter_code and left_letter_code, and a long gap or a long silence
// ends decoding for good (finished stays 1, later samples only update line_on).
// Every sample beat yields exactly one result beat, in order. The block takes one
// sample per clock cycle unless the result side stalls; a sample is held in the input
// register and then in the result register, with the state update in between. A
// stall on the result side holds both registers and drops sample.ready only when
// both are full. Configuration registers are written through cfg_wr_en, cfg_index
// and cfg_wr_data and should only change while no beat is in flight.
module light_pulse_morse_decoder_unit
  import lpmd_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wr_data,
  lpmd_in_if.sink                    sample,
  lpmd_out_if.source                 result
);

  lpmd_cfg_t    cfg;
  lpmd_result_t step_result;

  // input register
  logic               in_valid;
  logic [LEVEL_W-1:0] in_left_level;
  logic [LEVEL_W-1:0] in_right_level;
  logic [TIME_W-1:0]  in_time_ms;

  // result register
  logic         res_valid;
  lpmd_result_t res_data;

  logic line_on;
  logic advance;

  // a held sample moves on when the result register is empty or being drained
  assign advance      = in_valid && (!res_valid || result.ready);
  assign sample.ready = !in_valid || advance;

  lpmd_cfg_regs u_cfg_regs (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_wr_data (cfg_wr_data),
    .cfg         (cfg)
  );

  lpmd_line_detect u_line_detect (
    .left_level    (in_left_level),
    .right_level   (in_right_level),
    .trigger_level (cfg.trigger_level),
    .line_on       (line_on)
  );

  // decoder state only moves when the held sample advances
  lpmd_step_core u_step_core (
    .clk     (clk),
    .rst     (rst),
    .step    (advance),
    .line_on (line_on),
    .time_ms (in_time_ms),
    .cfg     (cfg),
    .result  (step_result)
  );

  // input register control
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (sample.ready) begin
      in_valid <= sample.valid;
    end
  end

  // input register payload
  always_ff @(posedge clk) begin
    if (sample.valid && sample.ready) begin
      in_left_level  <= sample.left_level;
      in_right_level <= sample.right_level;
      in_time_ms     <= sample.time_ms;
    end
  end

  // result register control
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  // result register payload
  always_ff @(posedge clk) begin
    if (advance) begin
      res_data <= step_result;
    end
  end

  assign result.valid        = res_valid;
  assign result.letter_event = res_data.letter_event;
  assign result.slot_index   = res_data.slot_index;
  assign result.finished     = res_data.finished;
  assign result.line_on      = res_data.line_on;

  // an empty result register must never hold back the sample side
  `LPMD_ASSERT(a_ready_when_empty, clk, rst, !res_valid |-> sample.ready, "sample stalled with empty result register")
  // no event and unknown letters never claim a slot
  `LPMD_ASSERT_NEVER(a_slot_without_turn, clk, rst, res_valid && (res_data.letter_event == EV_NONE || res_data.letter_event == EV_UNKNOWN) && res_data.slot_index != '0, "slot index without turn event")
  // once finished, every later result stays finished
  `LPMD_ASSERT(a_finished_sticky, clk, rst, res_valid && res_data.finished && result.ready |=> !res_valid || res_data.finished, "finished flag dropped")
  // after finishing, no further letter events appear
  `LPMD_ASSERT(a_no_event_after_done, clk, rst, res_valid && res_data.finished && result.ready |=> !res_valid || res_data.letter_event == EV_NONE, "letter event after finish")

endmodule
`default_nettype wire

/* rtl/core/lpmd_cfg_regs.sv */
// configuration register bank for the morse decoder
// depends on lpmd_pkg
`default_nettype none
module lpmd_cfg_regs
  import lpmd_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wr_data,
  output lpmd_cfg_t                  cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.trigger_level     <= TRIGGER_LEVEL_RST;
      cfg.short_limit_ms    <= SHORT_LIMIT_RST;
      cfg.long_limit_ms     <= LONG_LIMIT_RST;
      cfg.right_letter_code <= RIGHT_CODE_RST;
      cfg.left_letter_code  <= LEFT_CODE_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_TRIGGER_LEVEL: cfg.trigger_level     <= cfg_wr_data[LEVEL_W-1:0];
        REG_SHORT_LIMIT:   cfg.short_limit_ms    <= cfg_wr_data[LIMIT_W-1:0];
        REG_LONG_LIMIT:    cfg.long_limit_ms     <= cfg_wr_data[LIMIT_W-1:0];
        REG_RIGHT_CODE:    cfg.right_letter_code <= cfg_wr_data[CODE_W-1:0];
        REG_LEFT_CODE:     cfg.left_letter_code  <= cfg_wr_data[CODE_W-1:0];
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

/* rtl/core/lpmd_line_detect.sv */
// thresholds the two light samples into a single on/off line level
// depends on lpmd_pkg
`default_nettype none
module lpmd_line_detect
  import lpmd_pkg::*;
(
  input  wire logic [LEVEL_W-1:0] left_level,
  input  wire logic [LEVEL_W-1:0] right_level,
  input  wire logic [LEVEL_W-1:0] trigger_level,
  output logic                    line_on
);

  logic [LEVEL_W:0]   level_sum;
  logic [LEVEL_W-1:0] mean_level;
  logic [LEVEL_W-1:0] half_trigger;

  always_comb begin
    level_sum    = {1'b0, left_level} + {1'b0, right_level};
    mean_level   = level_sum[LEVEL_W:1];
    half_trigger = {1'b0, trigger_level[LEVEL_W-1:1]};
    line_on      = (mean_level > trigger_level) && (left_level > half_trigger)
                   && (right_level > half_trigger);
  end

endmodule
`default_nettype wire

/* rtl/core/lpmd_step_core.sv */
// edge timing, element pattern, letter match and slot counter state
// depends on lpmd_pkg
`default_nettype none
module lpmd_step_core
  import lpmd_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              step,
  input  wire logic              line_on,
  input  wire logic [TIME_W-1:0] time_ms,
  input  wire lpmd_cfg_t         cfg,
  output lpmd_result_t           result
);

  localparam logic [1:0] PH_LOW  = 2'd0;
  localparam logic [1:0] PH_HIGH = 2'd1;
  localparam logic [1:0] PH_DONE = 2'd2;

  logic [1:0]        phase, phase_next;
  logic              awaiting_first_edge, awaiting_first_edge_next;
  logic              previous_line, previous_line_next;
  logic [TIME_W-1:0] last_edge_time, last_edge_time_next;
  logic [CODE_W-1:0] element_pattern, element_pattern_next;
  logic [SLOT_W-1:0] slot_counter, slot_counter_next;

  logic [TIME_W-1:0] gap;
  logic              below_short;
  logic              below_long;
  logic              above_long;
  logic              do_match;
  logic [SLOT_W:0]   slot_inc;

  always_comb begin
    gap         = time_ms - last_edge_time;
    below_short = gap < TIME_W'(cfg.short_limit_ms);
    below_long  = gap < TIME_W'(cfg.long_limit_ms);
    above_long  = gap > TIME_W'(cfg.long_limit_ms);
    slot_inc    = {1'b0, slot_counter} + (SLOT_W+1)'(1);

    phase_next               = phase;
    awaiting_first_edge_next = awaiting_first_edge;
    previous_line_next       = previous_line;
    last_edge_time_next      = last_edge_time;
    element_pattern_next     = element_pattern;
    slot_counter_next        = slot_counter;
    do_match                 = 1'b0;
    result.letter_event      = EV_NONE;
    result.slot_index        = '0;

    unique case (phase)
      PH_LOW: begin
        if (line_on != previous_line) begin
          if (awaiting_first_edge) begin
            phase_next = PH_HIGH;
          end else if (below_short) begin
            element_pattern_next = {element_pattern[CODE_W-3:0], 2'b00};
            phase_next           = PH_HIGH;
          end else if (below_long) begin
            do_match   = 1'b1;
            phase_next = PH_HIGH;
          end else begin
            do_match   = 1'b1;
            phase_next = PH_DONE;
          end
          last_edge_time_next = time_ms;
          previous_line_next  = line_on;
        end else if (!awaiting_first_edge && above_long) begin
          // silence timeout
          do_match   = 1'b1;
          phase_next = PH_DONE;
        end
      end
      PH_HIGH: begin
        if (line_on != previous_line) begin
          element_pattern_next     = element_pattern | {6'd0, below_short ? ELEM_DOT : ELEM_DASH};
          awaiting_first_edge_next = 1'b0;
          last_edge_time_next      = time_ms;
          previous_line_next       = line_on;
          phase_next               = PH_LOW;
        end
      end
      default: ;
    endcase

    if (do_match) begin
      if (element_pattern == cfg.right_letter_code) begin
        result.letter_event = EV_RIGHT;
      end else if (element_pattern == cfg.left_letter_code) begin
        result.letter_event = EV_LEFT;
      end else begin
        result.letter_event = EV_UNKNOWN;
      end
      if (result.letter_event != EV_UNKNOWN) begin
        result.slot_index = SLOT_IDX_W'(slot_counter);
        slot_counter_next = (slot_inc >= (SLOT_W+1)'(BUFFER_SLOTS)) ? '0
                                                                    : slot_inc[SLOT_W-1:0];
      end
      element_pattern_next = '0;
    end

    result.finished = (phase_next == PH_DONE);
    result.line_on  = line_on;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase               <= PH_LOW;
      awaiting_first_edge <= 1'b1;
      previous_line       <= 1'b0;
      last_edge_time      <= '0;
      element_pattern     <= '0;
      slot_counter        <= '0;
    end else if (step) begin
      phase               <= phase_next;
      awaiting_first_edge <= awaiting_first_edge_next;
      previous_line       <= previous_line_next;
      last_edge_time      <= last_edge_time_next;
      element_pattern     <= element_pattern_next;
      slot_counter        <= slot_counter_next;
    end
  end

endmodule
`default_nettype wire
